// File: rtl/core/bts_pkg.sv
// Shared types and constants for the bilinear texture sampler.
// Depends on nothing; used by bilinear_texture_sampler.
package bts_pkg;

  localparam int unsigned WHITE_Q88 = 65280;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_VALID  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] u_coord;
    logic [31:0] v_coord;
    logic [15:0] texel_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } out_item_t;

endpackage

// File: rtl/core/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: queue ports, texel store, pipeline.
// Depends on bts_pkg, bts_front and bts_blend.
//
// channel | ports                          | transfer when
// in      | in_push, in_full, in_data      | in_push & !in_full
// out     | out_empty, out_pop, out_data   | out_pop & !out_empty
// cfg     | cfg_we, cfg_idx, cfg_wdata     | cfg_we
//
// One item per cycle unless in_full; results pass address, read, blend stages.
// Four texel reads per cycle come from four copies of the store.
// rst_n clears control only; the store is undefined until written.
// An eight-entry result queue absorbs the pipeline when out_pop stalls.
module bilinear_texture_sampler #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned TEXEL_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  bts_pkg::in_item_t    in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output bts_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [8:0]           cfg_wdata
);
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW = $clog2(TEXEL_DEPTH);
  localparam int unsigned QD = 8;

  logic [8:0] width_r, height_r;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd1;
      height_r <= 9'd1;
      valid_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bts_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        bts_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        bts_pkg::REG_VALID:  valid_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] clamp_side(input logic [8:0] s);
    logic [SW-1:0] r;
    if (s == 9'd0) r = SW'(1);
    else if (32'(s) > MAX_SIDE) r = SW'(MAX_SIDE);
    else r = SW'(s);
    return r;
  endfunction

  logic [SW-1:0] w, h, x0, x1, y0, y1;
  logic [15:0]   dx, dy;
  assign w = clamp_side(width_r);
  assign h = clamp_side(height_r);

  bts_front #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_fx (
    .coord(in_data.u_coord), .side(w), .i0(x0), .i1(x1), .wt(dx));
  bts_front #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_fy (
    .coord(in_data.v_coord), .side(h), .i0(y0), .i1(y1), .wt(dy));

  logic in_xfer;
  logic [3:0] cnt_r;
  logic [3:0] inflight;
  logic v1_r, v2_r, v3_r, wh1_r, wh2_r, wh3_r;
  assign in_xfer = in_push && !in_full;
  assign inflight = 4'(v1_r) + 4'(v2_r) + 4'(v3_r);
  assign in_full = (cnt_r + inflight) >= 4'(QD);

  logic is_samp;
  assign is_samp = in_xfer && (in_data.opcode == bts_pkg::OP_SAMPLE);

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] x,
      input logic [SW-1:0] y, input logic [SW-1:0] ww);
    logic [2*SW:0] a;
    a = (2*SW+1)'(y) * (2*SW+1)'(ww) + (2*SW+1)'(x);
    return AW'(a);
  endfunction

  // stage 1: registered addresses and weights
  logic [AW-1:0] a00_r, a10_r, a01_r, a11_r;
  logic [15:0]   dx1_r, dy1_r, dx2_r, dy2_r;
  always_ff @(posedge clk) begin
    a00_r <= addr_of(x0, y0, w);
    a10_r <= addr_of(x1, y0, w);
    a01_r <= addr_of(x0, y1, w);
    a11_r <= addr_of(x1, y1, w);
    dx1_r <= dx;
    dy1_r <= dy;
    dx2_r <= dx1_r;
    dy2_r <= dy1_r;
  end

  logic [23:0] m00 [TEXEL_DEPTH];
  logic [23:0] m10 [TEXEL_DEPTH];
  logic [23:0] m01 [TEXEL_DEPTH];
  logic [23:0] m11 [TEXEL_DEPTH];
  logic [23:0] t00_r, t10_r, t01_r, t11_r;
  logic        wen;
  logic [AW-1:0] wad;
  assign wen = in_xfer && (in_data.opcode == bts_pkg::OP_WRITE)
               && (32'(in_data.texel_index) < TEXEL_DEPTH);
  assign wad = AW'(in_data.texel_index);

  always_ff @(posedge clk) begin
    if (wen) begin
      m00[wad] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      m10[wad] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      m01[wad] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      m11[wad] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    t00_r <= m00[a00_r];
    t10_r <= m10[a10_r];
    t01_r <= m01[a01_r];
    t11_r <= m11[a11_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= is_samp; v2_r <= v1_r; v3_r <= v2_r;
    end
    wh1_r <= !valid_r; wh2_r <= wh1_r; wh3_r <= wh2_r;
  end

  logic [15:0] rr, gg, bb;
  bts_blend u_r (.clk(clk), .en1(v2_r), .a(t00_r[23:16]),
    .b(t10_r[23:16]), .c(t01_r[23:16]), .d(t11_r[23:16]),
    .dx(dx2_r), .dy(dy2_r), .res(rr));
  bts_blend u_g (.clk(clk), .en1(v2_r), .a(t00_r[15:8]),
    .b(t10_r[15:8]), .c(t01_r[15:8]), .d(t11_r[15:8]),
    .dx(dx2_r), .dy(dy2_r), .res(gg));
  bts_blend u_b (.clk(clk), .en1(v2_r), .a(t00_r[7:0]),
    .b(t10_r[7:0]), .c(t01_r[7:0]), .d(t11_r[7:0]),
    .dx(dx2_r), .dy(dy2_r), .res(bb));

  bts_pkg::out_item_t res;
  always_comb begin
    if (wh3_r) begin
      res.red_out   = 16'(bts_pkg::WHITE_Q88);
      res.green_out = 16'(bts_pkg::WHITE_Q88);
      res.blue_out  = 16'(bts_pkg::WHITE_Q88);
    end else begin
      res.red_out = rr; res.green_out = gg; res.blue_out = bb;
    end
  end

  bts_pkg::out_item_t q_r [QD];
  logic [2:0] wp_r, rp_r;
  logic       pop;
  assign pop = out_pop && !out_empty;
  assign out_empty = (cnt_r == 4'd0);
  assign out_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (v3_r) q_r[wp_r] <= res;
    if (!rst_n) begin
      wp_r <= 3'd0; rp_r <= 3'd0; cnt_r <= 4'd0;
    end else begin
      if (v3_r) wp_r <= wp_r + 3'd1;
      if (pop)  rp_r <= rp_r + 3'd1;
      cnt_r <= cnt_r + 4'(v3_r) - 4'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r + inflight) <= 4'(QD)) else $error("result queue overrun");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !is_samp) else $error("sample taken while full");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |=> v3_r) else $error("pipeline dropped item");
endmodule

// File: rtl/core/bts_front.sv
// Front part: axis split of a sample into cell indices and weights.
// Depends on nothing.
module bts_front #(
  parameter int unsigned MAX_SIDE = 256,
  parameter int unsigned SW = $clog2(MAX_SIDE + 1)
) (
  input  logic [31:0]   coord,
  input  logic [SW-1:0] side,
  output logic [SW-1:0] i0,
  output logic [SW-1:0] i1,
  output logic [15:0]   wt
);
  logic [SW-1:0]    sm1;
  logic [SW+15:0]   p;
  logic [SW:0]      nx;
  always_comb begin
    sm1 = side - SW'(1);
    p   = (SW+16)'(coord[15:0]) * (SW+16)'(sm1);
    i0  = p[SW+15:16];
    wt  = p[15:0];
    nx  = {1'b0, i0} + (SW+1)'(1);
    i1  = (nx < {1'b0, sm1}) ? nx[SW-1:0] : sm1;
  end
endmodule

// File: rtl/core/bts_blend.sv
// Back part: bilinear blend of one byte channel, x pass registered.
// Depends on nothing.
module bts_blend (
  input  logic        clk,
  input  logic        en1,
  input  logic [7:0]  a,
  input  logic [7:0]  b,
  input  logic [7:0]  c,
  input  logic [7:0]  d,
  input  logic [15:0] dx,
  input  logic [15:0] dy,
  output logic [15:0] res
);
  logic [24:0] top_r, bot_r;
  logic [16:0] dy_r;
  logic [16:0] ndx;
  logic [16:0] ndy;
  logic [41:0] all;
  always_comb begin
    ndx = 17'h10000 - 17'(dx);
    ndy = 17'h10000 - dy_r;
    all = 42'(top_r) * 42'(ndy) + 42'(bot_r) * 42'(dy_r);
    res = all[39:24];
  end
  always_ff @(posedge clk) begin
    if (en1) begin
      top_r <= 25'(a) * 25'(ndx) + 25'(b) * 25'(dx);
      bot_r <= 25'(c) * 25'(ndx) + 25'(d) * 25'(dx);
      dy_r  <= 17'(dy);
    end
  end
endmodule
